// ===== hdl/hlxd_pkg.sv =====
// ----------------------------------------------------------------------------
// hlxd_pkg
// Shared types and constants for the sync/length/XOR deframer.
// ----------------------------------------------------------------------------
package hlxd_pkg;

  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam logic [7:0]  HEADER_BYTES = 8'd3;
  localparam logic [7:0]  FLOOR_LENGTH = 8'd4;
  localparam logic [7:0]  SYNC_FIRST_RST  = 8'hAA;
  localparam logic [7:0]  SYNC_SECOND_RST = 8'h55;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SYNC_FIRST  = 2'd0,
    CFG_SYNC_SECOND = 2'd1,
    CFG_MIN_LENGTH  = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    PH_HUNT   = 2'd0,
    PH_SYNC2  = 2'd1,
    PH_LENGTH = 2'd2,
    PH_BODY   = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0] sync_first;
    logic [7:0] sync_second;
    logic [7:0] min_length;
  } cfg_t;

  typedef struct packed {
    logic [7:0] body_byte;
    logic       body_valid;
    logic [7:0] body_index;
    logic       frame_end;
    logic       frame_good;
  } result_t;

endpackage

// ===== hdl/header_length_xor_deframer.sv =====
// ----------------------------------------------------------------------------
// header_length_xor_deframer
// Finds sync/length/body/XOR-checksum frames in a byte stream.
// ----------------------------------------------------------------------------
// One word is accepted per cycle and each accepted word yields exactly one
// result word: an input register holds the byte, the frame decision is
// made in one pass of compare and XOR logic against the frame state, and an
// output register carries the result, so the sustained rate is one word per
// cycle whenever the result side takes words as fast.
module header_length_xor_deframer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_body_byte,
  output logic       out_body_valid,
  output logic [7:0] out_body_index,
  output logic       out_frame_end,
  output logic       out_frame_good,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import hlxd_pkg::*;

  cfg_t       cfg_r;
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       out_valid_r;
  result_t    out_r;
  result_t    res;
  logic       out_free;
  logic       advance;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_first  <= SYNC_FIRST_RST;
      cfg_r.sync_second <= SYNC_SECOND_RST;
      cfg_r.min_length  <= FLOOR_LENGTH;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SYNC_FIRST:  cfg_r.sync_first  <= cfg_data;
        CFG_SYNC_SECOND: cfg_r.sync_second <= cfg_data;
        CFG_MIN_LENGTH:  cfg_r.min_length  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_free = !out_valid_r || out_ready;
  assign advance  = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_rx_byte;
    end
    if (advance) begin
      out_r <= res;
    end
  end

  hlxd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .rx_byte (s1_byte_r),
    .cfg     (cfg_r),
    .res     (res)
  );

  assign out_valid      = out_valid_r;
  assign out_body_byte  = out_r.body_byte;
  assign out_body_valid = out_r.body_valid;
  assign out_body_index = out_r.body_index;
  assign out_frame_end  = out_r.frame_end;
  assign out_frame_good = out_r.frame_good;

endmodule

// ===== hdl/hlxd_parser.sv =====
// ----------------------------------------------------------------------------
// hlxd_parser
// Frame state and the per-byte decision logic; state advances on step.
// ----------------------------------------------------------------------------
module hlxd_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          rx_byte,
  input  hlxd_pkg::cfg_t      cfg,
  output hlxd_pkg::result_t   res
);
  import hlxd_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [7:0] length_r, length_nxt;
  logic [7:0] seen_r, seen_nxt;
  logic [7:0] xor_r, xor_nxt;
  logic [7:0] min_len;
  logic [8:0] seen_plus;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      length_r <= '0;
      seen_r   <= '0;
      xor_r    <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      length_r <= length_nxt;
      seen_r   <= seen_nxt;
      xor_r    <= xor_nxt;
    end
  end

  assign min_len   = (cfg.min_length < FLOOR_LENGTH) ? FLOOR_LENGTH : cfg.min_length;
  assign seen_plus = {1'b0, seen_r} + 9'd1;

  always_comb begin
    phase_nxt  = phase_r;
    length_nxt = length_r;
    seen_nxt   = seen_r;
    xor_nxt    = xor_r;
    res        = '0;
    unique case (phase_r)
      PH_HUNT: begin
        if (rx_byte == cfg.sync_first) begin
          xor_nxt   = rx_byte;
          seen_nxt  = 8'd1;
          phase_nxt = PH_SYNC2;
        end
      end
      PH_SYNC2: begin
        if (rx_byte == cfg.sync_second) begin
          xor_nxt   = xor_r ^ rx_byte;
          seen_nxt  = 8'd2;
          phase_nxt = PH_LENGTH;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
      PH_LENGTH: begin
        if (rx_byte < min_len) begin
          phase_nxt = PH_HUNT;
        end else begin
          length_nxt = rx_byte;
          xor_nxt    = xor_r ^ rx_byte;
          seen_nxt   = HEADER_BYTES;
          phase_nxt  = PH_BODY;
        end
      end
      PH_BODY: begin
        if (seen_plus >= {1'b0, length_r}) begin
          res.frame_end  = 1'b1;
          res.frame_good = (rx_byte == xor_r);
          phase_nxt      = PH_HUNT;
        end else begin
          res.body_valid = 1'b1;
          res.body_byte  = rx_byte;
          res.body_index = seen_r - HEADER_BYTES;
          xor_nxt        = xor_r ^ rx_byte;
          seen_nxt       = seen_plus[7:0];
        end
      end
      default: phase_nxt = PH_HUNT;
    endcase
  end

endmodule

// ===== hdl/hlxd_checker.sv =====
// ----------------------------------------------------------------------------
// hlxd_checker
// Port-level checks on the deframer's result channel.
// ----------------------------------------------------------------------------
module hlxd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_body_byte,
  input logic       out_body_valid,
  input logic [7:0] out_body_index,
  input logic       out_frame_end,
  input logic       out_frame_good
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_body_byte) &&
    $stable(out_body_index) && $stable(out_body_valid) && $stable(out_frame_end))
    else $error("result word changed while stalled");

  a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_body_valid && out_frame_end))
    else $error("body byte and frame end flagged together");

  a_good_needs_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_good |-> out_frame_end)
    else $error("frame_good without frame_end");

  a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_body_valid |-> out_body_byte == 8'd0 && out_body_index == 8'd0)
    else $error("body fields nonzero outside a body");

endmodule

bind header_length_xor_deframer hlxd_checker u_hlxd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_body_byte  (out_body_byte),
  .out_body_valid (out_body_valid),
  .out_body_index (out_body_index),
  .out_frame_end  (out_frame_end),
  .out_frame_good (out_frame_good)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sync/length/XOR-checksum deframer. Byte streams
// of well-formed frames with random bodies, corrupted checksums, broken
// headers and noise are pushed through the input channel under several
// register settings and handshake pacing modes. Each result word is compared
// field by field against a cycle-free model of the frame hunt.
// ----------------------------------------------------------------------------
module testbench;
  import hlxd_pkg::*;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_body_byte;
  logic       out_body_valid;
  logic [7:0] out_body_index;
  logic       out_frame_end;
  logic       out_frame_good;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = CFG_SYNC_FIRST;
  logic [7:0] cfg_data = 8'h00;

  header_length_xor_deframer dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_body_byte  (out_body_byte),
    .out_body_valid (out_body_valid),
    .out_body_index (out_body_index),
    .out_frame_end  (out_frame_end),
    .out_frame_good (out_frame_good),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  cfg_t       cfg_regs = '{sync_first: SYNC_FIRST_RST, sync_second: SYNC_SECOND_RST,
                           min_length: FLOOR_LENGTH};
  phase_t     hunt_state = PH_HUNT;
  logic [7:0] frame_len = 8'd0;
  logic [7:0] frame_count = 8'd0;
  logic [7:0] frame_xor = 8'd0;

  logic [7:0] tx_bytes[$];
  result_t    pending_results[$];
  result_t    want;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         error_count = 0;
  int         bytes_queued = 0;
  int         words_checked = 0;
  int         body_words = 0;
  int         frames_closed = 0;
  int         frames_good = 0;
  int         settings_used = 1;

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #3000000;
    $display("Timed out with %0d words still expected.", pending_results.size());
    $display("testbench: errors");
    $finish;
  end

  function automatic logic [7:0] eff_min_length();
    return (cfg_regs.min_length < FLOOR_LENGTH) ? FLOOR_LENGTH : cfg_regs.min_length;
  endfunction

  function automatic result_t deframe(input logic [7:0] b);
    result_t res;
    res = '0;
    case (hunt_state)
      PH_HUNT: begin
        if (b == cfg_regs.sync_first) begin
          frame_xor = b;
          frame_count = 8'd1;
          hunt_state = PH_SYNC2;
        end
      end
      PH_SYNC2: begin
        if (b == cfg_regs.sync_second) begin
          frame_xor = frame_xor ^ b;
          frame_count = 8'd2;
          hunt_state = PH_LENGTH;
        end else begin
          hunt_state = PH_HUNT;
        end
      end
      PH_LENGTH: begin
        if (b < eff_min_length()) begin
          hunt_state = PH_HUNT;
        end else begin
          frame_len = b;
          frame_xor = frame_xor ^ b;
          frame_count = HEADER_BYTES;
          hunt_state = PH_BODY;
        end
      end
      default: begin
        if ({1'b0, frame_count} + 9'd1 >= {1'b0, frame_len}) begin
          res.frame_end = 1'b1;
          res.frame_good = (b == frame_xor);
          hunt_state = PH_HUNT;
        end else begin
          res.body_valid = 1'b1;
          res.body_byte = b;
          res.body_index = frame_count - HEADER_BYTES;
          frame_xor = frame_xor ^ b;
          frame_count = frame_count + 8'd1;
        end
      end
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        pending_results.push_back(deframe(in_rx_byte));
      end
      if (!in_valid || in_ready) begin
        if (tx_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_rx_byte <= tx_bytes.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      if (error_count < 40) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
      end
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        if (error_count < 40) begin
          $display("%0t: result word with nothing expected, expected none, got %0h %0h %0h %0h %0h",
                   $time, out_body_byte, out_body_valid, out_body_index, out_frame_end,
                   out_frame_good);
        end
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("body_byte", want.body_byte, out_body_byte);
        check_field("body_valid", 8'(want.body_valid), 8'(out_body_valid));
        check_field("body_index", want.body_index, out_body_index);
        check_field("frame_end", 8'(want.frame_end), 8'(out_frame_end));
        check_field("frame_good", 8'(want.frame_good), 8'(out_frame_good));
        words_checked++;
        body_words += int'(want.body_valid);
        frames_closed += int'(want.frame_end);
        frames_good += int'(want.frame_good);
      end
    end
  end

  task automatic queue_byte(input logic [7:0] b);
    tx_bytes.push_back(b);
    bytes_queued++;
  endtask

  task automatic queue_frame(input int len, input bit corrupt);
    logic [7:0] sum;
    logic [7:0] b;
    sum = cfg_regs.sync_first ^ cfg_regs.sync_second ^ 8'(len);
    queue_byte(cfg_regs.sync_first);
    queue_byte(cfg_regs.sync_second);
    queue_byte(8'(len));
    for (int i = 0; i < len - 4; i++) begin
      b = 8'($urandom);
      queue_byte(b);
      sum = sum ^ b;
    end
    if (corrupt) begin
      sum = sum ^ 8'($urandom_range(255, 1));
    end
    queue_byte(sum);
  endtask

  task automatic program_regs(input logic [7:0] sf, input logic [7:0] ss,
                              input logic [7:0] ml);
    cfg_idx_t   idx[3] = '{CFG_SYNC_FIRST, CFG_SYNC_SECOND, CFG_MIN_LENGTH};
    logic [7:0] val[3] = '{sf, ss, ml};
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx[0];
    cfg_data <= val[0];
    for (int i = 0; i < 3; i++) begin
      do @(posedge clk); while (!cfg_ready);
      case (idx[i])
        CFG_SYNC_FIRST:  cfg_regs.sync_first = val[i];
        CFG_SYNC_SECOND: cfg_regs.sync_second = val[i];
        default:         cfg_regs.min_length = val[i];
      endcase
      if (i < 2) begin
        cfg_index <= idx[i + 1];
        cfg_data <= val[i + 1];
      end else begin
        cfg_valid <= 1'b0;
      end
    end
    settings_used++;
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (tx_bytes.size() != 0 || in_valid || pending_results.size() != 0);
  endtask

  initial begin
    int         r;
    int         len;
    int         emin;
    int         start;
    logic [7:0] b;
    logic [7:0] sf;
    logic [7:0] ss;
    while (!rst_n) @(posedge clk);
    @(negedge clk);
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 61;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 61;
        end
        default: begin
          send_idle_pct = 13;
          recv_stall_pct = 13;
        end
      endcase
      start = bytes_queued;
      sf = cfg_regs.sync_first;
      ss = cfg_regs.sync_second;
      if (ph == 0) begin
        queue_frame(4, 1'b0);
        queue_frame(4, 1'b1);
        // A repeated first sync byte in the second slot returns to the hunt without starting a new frame.
        queue_byte(sf);
        queue_byte(sf);
        queue_byte(ss);
        queue_byte(sf);
        queue_byte(ss);
        queue_byte(8'd3);
        queue_byte(sf);
        queue_byte(ss);
        queue_byte(8'd0);
        queue_byte(sf);
        queue_byte(ss);
        queue_byte(8'd6);
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_byte(sf ^ ss ^ 8'd6 ^ 8'hFF);
        start = bytes_queued + 20;
      end else begin
        b = 8'($urandom);
        case (ph)
          1: program_regs(8'h00, 8'hFF, 8'd0);
          2: program_regs(8'hFF, 8'h00, 8'd255);
          3: program_regs(b, b, FLOOR_LENGTH);
          default: program_regs(8'($urandom), 8'($urandom), 8'($urandom_range(12)));
        endcase
        @(negedge clk);
        sf = cfg_regs.sync_first;
        ss = cfg_regs.sync_second;
      end
      emin = int'(eff_min_length());
      while (bytes_queued - start < 200) begin
        r = $urandom_range(99);
        if (r < 72) begin
          if ($urandom_range(19) == 0) begin
            len = $urandom_range(255, emin);
          end else begin
            len = emin + $urandom_range(12);
          end
          if (len > 255) begin
            len = 255;
          end
          queue_frame(len, r >= 60);
        end else if (r < 80) begin
          queue_byte(sf);
          if (sf != ss && $urandom_range(1) == 1) begin
            b = sf;
          end else begin
            do b = 8'($urandom); while (b == ss);
          end
          queue_byte(b);
        end else if (r < 88) begin
          queue_byte(sf);
          queue_byte(ss);
          queue_byte(8'($urandom_range(emin - 1)));
        end else begin
          repeat ($urandom_range(6, 1)) queue_byte(8'($urandom));
        end
      end
      wait_drained();
    end
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d expected words never arrived, expected %0h %0h %0h %0h %0h, got none",
               $time, pending_results.size(), pending_results[0].body_byte,
               pending_results[0].body_valid, pending_results[0].body_index,
               pending_results[0].frame_end, pending_results[0].frame_good);
      error_count++;
    end
    $display("Sent %0d bytes over %0d register settings; checked %0d result words.",
             bytes_queued, settings_used, words_checked);
    $display("Saw %0d body bytes and %0d closed frames, %0d of them with a good checksum.",
             body_words, frames_closed, frames_good);
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
